@@ design/tmt_pkg.sv @@
`timescale 1ns / 1ps

package tmt_pkg;

   localparam int SET_SIZE    = 10;
   localparam int SAMPLE_BITS = 16;

   localparam int FILL_BITS = $clog2(SET_SIZE + 1);
   localparam int CNT_BITS  = $clog2(SET_SIZE);
   localparam int SUM_BITS  = SAMPLE_BITS + $clog2(SET_SIZE);
   localparam int MAG_BITS  = SUM_BITS;
   localparam int TRIM_BITS = 2;

   localparam logic [TRIM_BITS-1:0] TRIM_RESET = TRIM_BITS'(1);

   localparam int KEEP_WIDE   = SET_SIZE - 2;
   localparam int KEEP_NARROW = SET_SIZE - 4;

   localparam logic [MAG_BITS-1:0] DIV_WIDE    = MAG_BITS'(KEEP_WIDE);
   localparam logic [MAG_BITS-1:0] DIV_NARROW  = MAG_BITS'(KEEP_NARROW);
   localparam logic [MAG_BITS-1:0] HALF_WIDE   = MAG_BITS'(KEEP_WIDE / 2);
   localparam logic [MAG_BITS-1:0] HALF_NARROW = MAG_BITS'(KEEP_NARROW / 2);
   localparam logic [MAG_BITS-1:0] RECIP_WIDE  =
      MAG_BITS'((64'd1 << MAG_BITS) / KEEP_WIDE);
   localparam logic [MAG_BITS-1:0] RECIP_NARROW =
      MAG_BITS'((64'd1 << MAG_BITS) / KEEP_NARROW);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;

   typedef struct packed {
      sample_type value;
      logic       greater;
   } cell_link_type;

   typedef struct packed {
      logic go;
      logic narrow;
   } set_start_type;

endpackage

@@ design/tmt_sort_cell.sv @@
`timescale 1ns / 1ps

module tmt_sort_cell
   import tmt_pkg::*;
(
   input  logic          clock,
   input  logic          insert,
   input  logic          occupied,
   input  sample_type    sample,
   input  cell_link_type left_link,
   output cell_link_type right_link,
   output sample_type    next_value
);

   sample_type value_ff;
   sample_type value_in;
   logic       greater;

   // empty cells count as larger than any sample
   always_comb begin
      greater = !occupied || (value_ff > sample);
      if (!greater) begin
         value_in = value_ff;
      end else if (left_link.greater) begin
         value_in = left_link.value;
      end else begin
         value_in = sample;
      end
   end

   always_ff @(posedge clock) begin
      if (insert) begin
         value_ff <= value_in;
      end
   end

   assign right_link = '{value: value_ff, greater: greater};
   assign next_value = value_in;

endmodule

@@ design/tmt_mean_unit.sv @@
`timescale 1ns / 1ps

module tmt_mean_unit
   import tmt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  set_start_type start,
   input  sample_type    set_values [SET_SIZE],
   output logic          busy,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output sample_type    rsp_mean_value
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_ACCUM = 6'b000010,
      S_MAG   = 6'b000100,
      S_MUL   = 6'b001000,
      S_FIX   = 6'b010000,
      S_SEND  = 6'b100000
   } mean_state_type;

   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(SET_SIZE - 1);

   mean_state_type      state_ff, state_in;
   sample_type          snap_ff [SET_SIZE];
   logic [SET_SIZE-1:0] keep_ff;
   logic                narrow_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   sum_type             acc_ff;
   logic                neg_ff;
   logic [MAG_BITS-1:0] mag_ff;
   logic [MAG_BITS-1:0] q0_ff;
   sample_type          mean_ff;

   logic [SET_SIZE-1:0]   keep_in;
   logic [MAG_BITS-1:0]   div_sel, half_sel, recip_sel;
   logic [2*MAG_BITS-1:0] prod;
   logic [MAG_BITS-1:0]   back, rem, quot;
   sample_type            quot_s;

   always_comb begin
      for (int i = 0; i < SET_SIZE; i++) begin
         if (start.narrow) begin
            keep_in[i] = (i >= 2) && (i < SET_SIZE - 2);
         end else begin
            keep_in[i] = (i >= 1) && (i < SET_SIZE - 1);
         end
      end
   end

   assign div_sel   = narrow_ff ? DIV_NARROW : DIV_WIDE;
   assign half_sel  = narrow_ff ? HALF_NARROW : HALF_WIDE;
   assign recip_sel = narrow_ff ? RECIP_NARROW : RECIP_WIDE;

   assign prod   = (2*MAG_BITS)'(mag_ff) * (2*MAG_BITS)'(recip_sel);
   assign back   = q0_ff * div_sel;
   assign rem    = mag_ff - back;
   assign quot   = (rem >= div_sel) ? q0_ff + MAG_BITS'(1) : q0_ff;
   assign quot_s = SAMPLE_BITS'(quot);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (start.go) state_in = S_ACCUM;
         S_ACCUM: if (cnt_ff == CNT_LAST) state_in = S_MAG;
         S_MAG:   state_in = S_MUL;
         S_MUL:   state_in = S_FIX;
         S_FIX:   state_in = S_SEND;
         S_SEND:  if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start.go) begin
         snap_ff   <= set_values;
         keep_ff   <= keep_in;
         narrow_ff <= start.narrow;
         cnt_ff    <= '0;
         acc_ff    <= '0;
      end else if (state_ff == S_ACCUM) begin
         // drain the snapshot one entry a cycle into the accumulator
         for (int i = 0; i < SET_SIZE - 1; i++) begin
            snap_ff[i] <= snap_ff[i+1];
         end
         keep_ff <= keep_ff >> 1;
         cnt_ff  <= cnt_ff + CNT_BITS'(1);
         if (keep_ff[0]) begin
            acc_ff <= acc_ff + sum_type'(snap_ff[0]);
         end
      end
      if (state_ff == S_MAG) begin
         neg_ff <= acc_ff[SUM_BITS-1];
         mag_ff <= MAG_BITS'(acc_ff[SUM_BITS-1] ? -acc_ff : acc_ff) + half_sel;
      end
      if (state_ff == S_MUL) begin
         q0_ff <= prod[2*MAG_BITS-1:MAG_BITS];
      end
      if (state_ff == S_FIX) begin
         mean_ff <= neg_ff ? -quot_s : quot_s;
      end
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = (state_ff == S_SEND);
   assign rsp_mean_value = mean_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start.go |-> state_ff == S_IDLE)
      else $error("set started while mean unit busy");

   a_accum_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACCUM && cnt_ff == CNT_LAST) |=> state_ff == S_MAG)
      else $error("accumulation did not end after one full set");

   a_recip_error: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIX |-> rem < (div_sel << 1))
      else $error("reciprocal quotient off by more than one");

   a_fix_to_send: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIX |=> rsp_valid)
      else $error("result not presented after correction");

endmodule

@@ design/trimmed_mean_of_ten.sv @@
`timescale 1ns / 1ps

// channel  direction  handshake             payload
// req      in         req_valid/req_stall   req_sample (16b signed)
// rsp      out        rsp_valid/rsp_stall   rsp_mean_value (16b signed)
// csr      in         csr_write_enable      csr_write_data (2b trim count)
//
// one sample is accepted per cycle into the insertion chain while req_stall is low
// the set-completing sample starts a drain of all SET_SIZE set entries, then
// rounding and scaling in S_MAG, S_MUL and S_FIX; rsp_valid rises in S_SEND
// that sample is stalled only while the previous result is still in flight
// synchronous reset empties the set, sets the trim count to 1 and stalls req

module trimmed_mean_of_ten
   import tmt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sample_type           req_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sample_type           rsp_mean_value,
   input  logic                 csr_write_enable,
   input  logic [TRIM_BITS-1:0] csr_write_data
);

   localparam logic [FILL_BITS-1:0] FILL_LAST = FILL_BITS'(SET_SIZE - 1);

   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic [TRIM_BITS-1:0] trim_ff;
   logic                 accept;
   logic                 set_done;
   logic                 busy;
   cell_link_type        links [SET_SIZE+1];
   sample_type           set_values [SET_SIZE];
   set_start_type        start;

   assign req_stall = reset || (busy && (fill_ff == FILL_LAST));
   assign accept    = req_valid && !req_stall;
   assign set_done  = accept && (fill_ff == FILL_LAST);

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         fill_in = set_done ? '0 : fill_ff + FILL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         trim_ff <= TRIM_RESET;
      end else begin
         fill_ff <= fill_in;
         if (csr_write_enable) begin
            trim_ff <= csr_write_data;
         end
      end
   end

   assign links[0] = '{value: '0, greater: 1'b0};

   for (genvar i = 0; i < SET_SIZE; i++) begin : g_cell
      tmt_sort_cell u_cell (
         .clock      (clock),
         .insert     (accept),
         .occupied   (fill_ff > FILL_BITS'(i)),
         .sample     (req_sample),
         .left_link  (links[i]),
         .right_link (links[i+1]),
         .next_value (set_values[i])
      );
   end

   // trim codes 2 and 3 drop two at each end, 0 and 1 drop one
   assign start = '{go: set_done, narrow: trim_ff[1]};

   tmt_mean_unit u_mean (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .set_values     (set_values),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mean_value (rsp_mean_value)
   );

   a_last_cell_free: assert property (@(posedge clock) disable iff (reset)
      links[SET_SIZE].greater)
      else $error("last cell occupied before set completes");

   a_fill_restart: assert property (@(posedge clock) disable iff (reset)
      set_done |=> fill_ff == '0 && busy)
      else $error("set completion did not restart fill and start mean unit");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_LAST)
      else $error("fill count beyond set size");

endmodule

@@ tb/trimmed_mean_of_ten_tb.sv @@
`timescale 1ns / 1ps

module trimmed_mean_of_ten_tb;
   import tmt_pkg::*;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam int TRIM_LEAST = 1;
   localparam int TRIM_MOST  = 2;
   localparam int QUIET_CYCLES = SET_SIZE + 8;
   localparam int DRAIN_LIMIT = 20000;
   localparam int PRINT_LIMIT = 20;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   sample_type           req_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   sample_type           rsp_mean_value;
   logic                 csr_write_enable = 1'b0;
   logic [TRIM_BITS-1:0] csr_write_data = '0;

   sample_type           set_held[$];
   sample_type           expected_means[$];
   logic [TRIM_BITS-1:0] trim_setting = TRIM_RESET;
   sample_type           last_sample = '0;
   int                   mismatch_count = 0;
   int                   req_gap_pct = 0;
   int                   rsp_stall_pct = 0;
   int                   hold_off_cycles = 0;

   trimmed_mean_of_ten u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mean_value   (rsp_mean_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic sample_type trimmed_mean(input sample_type sorted_set[$],
                                               input logic [TRIM_BITS-1:0] trim);
      int     cut;
      longint kept;
      longint total;
      longint mean;
      cut = (trim >= TRIM_MOST) ? TRIM_MOST : TRIM_LEAST;
      kept = SET_SIZE - 2 * cut;
      total = 0;
      for (int i = cut; i < SET_SIZE - cut; i++) begin
         total += sorted_set[i];
      end
      // ties round away from zero
      if (total >= 0) begin
         mean = (total + kept / 2) / kept;
      end else begin
         mean = -((-total + kept / 2) / kept);
      end
      return sample_type'(mean);
   endfunction

   function automatic void take_sample(input sample_type value);
      int pos;
      pos = set_held.size();
      // equal values stay in arrival order
      while (pos > 0 && set_held[pos-1] > value) begin
         pos--;
      end
      set_held.insert(pos, value);
      if (set_held.size() == SET_SIZE) begin
         expected_means.push_back(trimmed_mean(set_held, trim_setting));
         set_held = {};
      end
   endfunction

   function automatic sample_type next_random_sample();
      sample_type value;
      case ($urandom_range(9))
         0: value = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
         1, 2: value = sample_type'($signed($urandom_range(16)) - 8);
         3: value = last_sample;
         default: value = sample_type'($urandom);
      endcase
      last_sample = value;
      return value;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   task automatic send_sample(input sample_type value);
      @(negedge clock);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= value;
      do begin
         @(posedge clock);
      end while (req_stall);
      take_sample(value);
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_means.size() != 0) begin
         @(negedge clock);
      end
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_trim(input logic [TRIM_BITS-1:0] value);
      wait_quiet();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      trim_setting = value;
   endtask

   task automatic set_idling(input int gap_pct, input int stall_pct);
      req_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // extremes, repeated values and a positive tie with the reset trim
   task automatic test_positive_tie_extremes();
      sample_type items[$];
      items = '{SAMPLE_MAX, 16'sd5, SAMPLE_MIN, 16'sd5, 16'sd0,
                SAMPLE_MAX, 16'sd5, SAMPLE_MIN, 16'sd1, 16'sd5};
      foreach (items[i]) begin
         send_sample(items[i]);
      end
   endtask

   // negative tie, trim changed halfway through the set to the out of range top value
   task automatic test_negative_tie_mid_set_trim();
      sample_type items[$];
      items = '{SAMPLE_MAX, -16'sd1, SAMPLE_MIN, 16'sd0, SAMPLE_MIN,
                16'sd0, SAMPLE_MAX, -16'sd1, SAMPLE_MIN, SAMPLE_MAX};
      for (int i = 0; i < SET_SIZE / 2; i++) begin
         send_sample(items[i]);
      end
      write_trim(2'd3);
      for (int i = SET_SIZE / 2; i < SET_SIZE; i++) begin
         send_sample(items[i]);
      end
   endtask

   // runs of random samples with a new trim between runs, often mid-set
   task automatic test_random_sets(input int item_total, input logic [TRIM_BITS-1:0] first_trim);
      int sent;
      int run;
      write_trim(first_trim);
      sent = 0;
      while (sent < item_total) begin
         run = $urandom_range(60, 5);
         for (int i = 0; i < run; i++) begin
            send_sample(next_random_sample());
         end
         sent += run;
         write_trim(TRIM_BITS'($urandom_range(3)));
      end
   endtask

   // long output hold-off while samples keep coming, so the input backs up
   task automatic test_output_hold_off();
      set_idling(0, 0);
      for (int i = 0; i < 3; i++) begin
         send_sample(next_random_sample());
      end
      hold_off_cycles = 400;
      for (int i = 0; i < 80; i++) begin
         send_sample(next_random_sample());
      end
      wait_quiet();
   endtask

   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles = hold_off_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_means
      sample_type wanted;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_means.size() == 0) begin
            report_mismatch($sformatf("mean %0d with no set completed", rsp_mean_value));
         end else begin
            wanted = expected_means.pop_front();
            if (rsp_mean_value !== wanted) begin
               report_mismatch($sformatf("mean %0d, wanted %0d", rsp_mean_value, wanted));
            end
         end
      end
   end

   initial begin
      int waited;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      set_idling(6, 59);
      test_positive_tie_extremes();
      test_negative_tie_mid_set_trim();
      test_random_sets(510, 2'd0);
      set_idling(59, 6);
      test_random_sets(510, 2'd2);
      set_idling(0, 0);
      test_random_sets(450, 2'd1);
      test_output_hold_off();
      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (expected_means.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (expected_means.size() != 0) begin
         report_mismatch($sformatf("%0d means never arrived", expected_means.size()));
      end
      repeat (QUIET_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
